### rtl/ppmb_pkg.sv
// Package for the PPM ballistics block: widths, codes, register defaults,
// the configuration struct and the rectifier helper.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppmb_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 24;
  localparam int GAIN_BITS     = 16;
  localparam int ENV_FRAC_BITS = 8;
  localparam int ENV_BITS      = SAMPLE_BITS + ENV_FRAC_BITS;   // 32
  localparam int HOLD_BITS     = ENV_BITS + 1;                  // 33
  localparam int LEVEL_BITS    = 24;
  localparam int GROUP_SIZE    = 4;
  localparam int SAMP_IDX_BITS = 2;

  // Shared multiplier: (a * b) >> COEF_BITS for every operation
  localparam int MUL_A_BITS = HOLD_BITS;
  localparam int MUL_B_BITS = COEF_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int SHR_BITS   = PROD_BITS - COEF_BITS;            // 33

  // Operation sequence of a process item: two decays, then slow/fast
  // attack pairs, one pair per sample
  localparam int NUM_OPS = 2 + 2 * GROUP_SIZE;
  localparam int OP_BITS = 4;

  // Action codes
  localparam logic [1:0] ACT_PROCESS = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESET   = 2'd2;

  // Register indexes
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_SLOW_ATTACK = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FAST_ATTACK = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY       = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN        = 2'd3;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // Register reset values
  localparam logic [COEF_BITS-1:0] SLOW_ATTACK_RST = 24'd69905;
  localparam logic [COEF_BITS-1:0] FAST_ATTACK_RST = 24'd300590;
  localparam logic [COEF_BITS-1:0] DECAY_RST       = 24'd16775818;
  localparam logic [GAIN_BITS-1:0] GAIN_RST        = 16'd33692;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

  typedef struct packed {
    logic [COEF_BITS-1:0] slow_attack_coef;
    logic [COEF_BITS-1:0] fast_attack_coef;
    logic [COEF_BITS-1:0] decay_coef;
    logic [GAIN_BITS-1:0] output_gain;
  } cfg_regs_t;

  // |sample| with envelope fraction bits appended; the most negative
  // sample maps to a magnitude of 2^23 (2^31 with the fraction bits)
  function automatic logic [ENV_BITS-1:0] rectify(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mag;
    mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    return {mag, {ENV_FRAC_BITS{1'b0}}};
  endfunction

endpackage

`default_nettype wire

### rtl/ppmb_mul.sv
// Shared unsigned multiplier of the PPM ballistics block, product registered.
// Depends on ppmb_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module ppmb_mul (
  input  wire logic                           clk,
  input  wire logic [ppmb_pkg::MUL_A_BITS-1:0] a,
  input  wire logic [ppmb_pkg::MUL_B_BITS-1:0] b,
  output logic      [ppmb_pkg::PROD_BITS-1:0]  prod_r
);

  // One multiply per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= ppmb_pkg::PROD_BITS'(a) * ppmb_pkg::PROD_BITS'(b);
  end

endmodule

`default_nettype wire

### rtl/ppmb_cfg.sv
// APB-style register file of the PPM ballistics block (four registers).
// Depends on ppmb_pkg for register indexes, defaults and cfg_regs_t.
`timescale 1ns / 1ps
`default_nettype none

module ppmb_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ppmb_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [ppmb_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [ppmb_pkg::DATA_BITS-1:0]  prdata,
  output logic                                 pready,
  output ppmb_pkg::cfg_regs_t                  cfg
);

  ppmb_pkg::cfg_regs_t              cfg_r;
  logic [ppmb_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[ppmb_pkg::ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_attack_coef <= ppmb_pkg::SLOW_ATTACK_RST;
      cfg_r.fast_attack_coef <= ppmb_pkg::FAST_ATTACK_RST;
      cfg_r.decay_coef       <= ppmb_pkg::DECAY_RST;
      cfg_r.output_gain      <= ppmb_pkg::GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ppmb_pkg::REG_SLOW_ATTACK:
          cfg_r.slow_attack_coef <= pwdata[ppmb_pkg::COEF_BITS-1:0];
        ppmb_pkg::REG_FAST_ATTACK:
          cfg_r.fast_attack_coef <= pwdata[ppmb_pkg::COEF_BITS-1:0];
        ppmb_pkg::REG_DECAY:
          cfg_r.decay_coef       <= pwdata[ppmb_pkg::COEF_BITS-1:0];
        ppmb_pkg::REG_GAIN:
          cfg_r.output_gain      <= pwdata[ppmb_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      ppmb_pkg::REG_SLOW_ATTACK:
        prdata = ppmb_pkg::DATA_BITS'(cfg_r.slow_attack_coef);
      ppmb_pkg::REG_FAST_ATTACK:
        prdata = ppmb_pkg::DATA_BITS'(cfg_r.fast_attack_coef);
      ppmb_pkg::REG_DECAY:
        prdata = ppmb_pkg::DATA_BITS'(cfg_r.decay_coef);
      ppmb_pkg::REG_GAIN:
        prdata = ppmb_pkg::DATA_BITS'(cfg_r.output_gain);
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ppmb_core.sv
// Sequencer and state of the PPM ballistics block: envelopes, hold,
// operand setup for the shared multiplier, writeback and the result register.
// Depends on ppmb_pkg and ppmb_mul.
`timescale 1ns / 1ps
`default_nettype none

module ppmb_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ppmb_pkg::cfg_regs_t               cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_0,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_1,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_2,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_3,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ppmb_pkg::LEVEL_BITS-1:0]   out_level
);

  localparam int ENV_BITS  = ppmb_pkg::ENV_BITS;
  localparam int HOLD_BITS = ppmb_pkg::HOLD_BITS;
  localparam int OP_BITS   = ppmb_pkg::OP_BITS;
  localparam logic [OP_BITS-1:0] LAST_OP = OP_BITS'(ppmb_pkg::NUM_OPS - 1);
  localparam logic [OP_BITS-1:0] FIRST_ATTACK_OP = OP_BITS'(2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // Control and state
  logic [2:0]           state_r, state_nxt;
  logic [OP_BITS-1:0]   op_r, op_nxt;
  logic                 is_read_r, is_read_nxt;
  logic [ENV_BITS-1:0]  slow_r, slow_nxt;
  logic [ENV_BITS-1:0]  fast_r, fast_nxt;
  logic [HOLD_BITS-1:0] hold_r, hold_nxt;
  logic                 clear_r, clear_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload
  logic [ppmb_pkg::SAMPLE_BITS-1:0] samp_r [ppmb_pkg::GROUP_SIZE];
  logic [ppmb_pkg::MUL_A_BITS-1:0]  a_r, a_nxt;
  logic [ppmb_pkg::MUL_B_BITS-1:0]  b_r, b_nxt;
  logic                             wb_en_r, wb_en_nxt;
  logic [ppmb_pkg::LEVEL_BITS-1:0]  level_r, level_nxt;
  logic                             load_ops;

  logic [ppmb_pkg::PROD_BITS-1:0]   prod_r;
  logic [ppmb_pkg::SHR_BITS-1:0]    prod_sh;

  // Operand setup signals
  logic [OP_BITS-1:0]                setup_idx;
  logic [ppmb_pkg::SAMP_IDX_BITS-1:0] samp_sel;
  logic [ENV_BITS-1:0]               env_sel;
  logic [ENV_BITS-1:0]               t_val;
  logic [ppmb_pkg::COEF_BITS-1:0]    att_coef;

  // Writeback signals
  logic [ENV_BITS-1:0]  env_tgt;
  logic [ENV_BITS:0]    add_sum;
  logic [ENV_BITS-1:0]  env_new;
  logic [HOLD_BITS-1:0] env_sum;
  logic [HOLD_BITS-1:0] hold_base;
  logic                 accept;
  logic                 out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_level = level_r;
  assign out_free  = !out_valid_r || out_ready;
  assign prod_sh   = prod_r[ppmb_pkg::PROD_BITS-1:ppmb_pkg::COEF_BITS];

  // Shared multiplier
  ppmb_mul u_mul (
    .clk    (clk),
    .a      (a_r),
    .b      (b_r),
    .prod_r (prod_r)
  );

  // Operand setup for the next op: first op from SETUP, following ones
  // while the previous op writes back (they touch the other envelope).
  // A read keeps its operands so the product holds while the result waits.
  always_comb begin
    setup_idx = (state_r == ST_SETUP) ? '0 : OP_BITS'(op_r + 1'b1);
    samp_sel  = ppmb_pkg::SAMP_IDX_BITS'(setup_idx[OP_BITS-1:1] - 3'd1);
    env_sel   = setup_idx[0] ? fast_r : slow_r;
    t_val     = ppmb_pkg::rectify(samp_r[samp_sel]);
    att_coef  = setup_idx[0] ? cfg.fast_attack_coef : cfg.slow_attack_coef;
    if (state_r == ST_SETUP && is_read_r) begin
      a_nxt     = hold_r;
      b_nxt     = ppmb_pkg::MUL_B_BITS'(cfg.output_gain);
      wb_en_nxt = 1'b1;
    end else if (setup_idx < FIRST_ATTACK_OP) begin
      a_nxt     = ppmb_pkg::MUL_A_BITS'(env_sel);
      b_nxt     = cfg.decay_coef;
      wb_en_nxt = 1'b1;
    end else begin
      a_nxt     = ppmb_pkg::MUL_A_BITS'(t_val - env_sel);
      b_nxt     = att_coef;
      wb_en_nxt = (t_val > env_sel);
    end
    load_ops = (state_r == ST_SETUP) || (state_r == ST_WB && !is_read_r);
  end

  // Writeback datapath
  always_comb begin
    env_tgt   = op_r[0] ? fast_r : slow_r;
    add_sum   = {1'b0, env_tgt} + {1'b0, prod_sh[ENV_BITS-1:0]};
    env_new   = (op_r < FIRST_ATTACK_OP) ? prod_sh[ENV_BITS-1:0] : add_sum[ENV_BITS-1:0];
    env_sum   = {1'b0, slow_r} + {1'b0, fast_r};
    hold_base = clear_r ? '0 : hold_r;
    level_nxt = (|prod_sh[ppmb_pkg::SHR_BITS-1:ppmb_pkg::LEVEL_BITS]) ?
                ppmb_pkg::LEVEL_MAX : prod_sh[ppmb_pkg::LEVEL_BITS-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    is_read_nxt   = is_read_r;
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    hold_nxt      = hold_r;
    clear_nxt     = clear_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        op_nxt = '0;
        if (accept) begin
          unique case (in_action)
            ppmb_pkg::ACT_PROCESS: begin
              is_read_nxt = 1'b0;
              state_nxt   = ST_SETUP;
            end
            ppmb_pkg::ACT_READ: begin
              is_read_nxt = 1'b1;
              state_nxt   = ST_SETUP;
            end
            ppmb_pkg::ACT_RESET: begin
              slow_nxt  = '0;
              fast_nxt  = '0;
              hold_nxt  = '0;
              clear_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WB;
      ST_WB: begin
        if (is_read_r) begin
          // hold here until the result register is free
          if (out_free) begin
            out_valid_nxt = 1'b1;
            clear_nxt     = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          if (wb_en_r) begin
            if (op_r[0]) fast_nxt = env_new;
            else         slow_nxt = env_new;
          end
          if (op_r == LAST_OP) begin
            state_nxt = ST_FIN;
          end else begin
            op_nxt    = OP_BITS'(op_r + 1'b1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        hold_nxt  = (env_sum > hold_base) ? env_sum : hold_base;
        clear_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= '0;
      is_read_r   <= 1'b0;
      slow_r      <= '0;
      fast_r      <= '0;
      hold_r      <= '0;
      clear_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      is_read_r   <= is_read_nxt;
      slow_r      <= slow_nxt;
      fast_r      <= fast_nxt;
      hold_r      <= hold_nxt;
      clear_r     <= clear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r[0] <= in_sample_0;
      samp_r[1] <= in_sample_1;
      samp_r[2] <= in_sample_2;
      samp_r[3] <= in_sample_3;
    end
    if (load_ops) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      wb_en_r <= wb_en_nxt;
    end
    if (state_r == ST_WB && is_read_r && out_free) begin
      level_r <= level_nxt;
    end
  end

  // Checks
  a_attack_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && !is_read_r && wb_en_r && op_r >= FIRST_ATTACK_OP)
      |-> !add_sum[ENV_BITS])
    else $error("envelope attack overflowed");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WB && is_read_r))
    else $error("result raised outside read writeback");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (!clear_r && state_r == ST_IDLE))
    else $error("hold update did not finish the group");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (op_r <= LAST_OP))
    else $error("op counter out of range");

endmodule

`default_nettype wire

### rtl/iec_type2_ppm_ballistics_unit.sv
// Top level of the IEC type II PPM ballistics block.
// Depends on ppmb_pkg, ppmb_cfg, ppmb_core (which holds ppmb_mul).
//
//  channel   handshake             payload
//  in_       in_valid/in_ready     in_action, in_sample_0..in_sample_3
//  out_      out_valid/out_ready   out_level
//  cfg       psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// After a process item is accepted in_ready stays low for one operand setup,
// ten multiply and writeback pairs (two decays, eight attacks) through the
// one shared multiplier and then the hold update; a new process item is taken
// only once the last is through. A read item keeps in_ready low through its
// setup, multiply and writeback states and any wait for the result register;
// reset and unused items leave it high. rst_n is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module iec_type2_ppm_ballistics_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_0,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_1,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_2,
  input  wire logic [ppmb_pkg::SAMPLE_BITS-1:0]  in_sample_3,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ppmb_pkg::LEVEL_BITS-1:0]   out_level,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppmb_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [ppmb_pkg::DATA_BITS-1:0]    pwdata,
  output logic      [ppmb_pkg::DATA_BITS-1:0]    prdata,
  output logic                                   pready
);

  ppmb_pkg::cfg_regs_t cfg;

  // Register file
  ppmb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer and datapath
  ppmb_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_sample_0 (in_sample_0),
    .in_sample_1 (in_sample_1),
    .in_sample_2 (in_sample_2),
    .in_sample_3 (in_sample_3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level)
  );

endmodule

`default_nettype wire
